// File: rtl/core/hgd_pkg.sv
// shared constants and codes for the heat grid diffusion step unit
`default_nettype none
package hgd_pkg;
	localparam int MAX_COLS_DEF = 64;
	localparam int MAX_ROWS_DEF = 64;

	localparam int HEAT_W = 32;
	localparam int DIFF_W = 32;
	localparam int IDX_W  = 6;
	localparam int KIND_W = 3;
	localparam int DIM_W  = 7;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [KIND_W-1:0] KIND_WR_HEAT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_WR_DIFF = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RD_HEAT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STEP    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FILL    = 3'd4;

	localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
	localparam logic [2:0] REG_STEP_GAIN   = 3'd2;
	localparam logic [2:0] REG_AMBIENT     = 3'd3;
	localparam logic [2:0] REG_DISSIPATION = 3'd4;

	localparam logic [DIM_W-1:0]   GRID_WIDTH_RST  = 7'd64;
	localparam logic [DIM_W-1:0]   GRID_HEIGHT_RST = 7'd64;
	localparam logic [31:0]        STEP_GAIN_RST   = 32'd65536;
	localparam logic signed [31:0] AMBIENT_RST     = 32'sd0;
	localparam logic [31:0]        DISSIPATION_RST = 32'd1099512;
endpackage
`default_nettype wire

// File: rtl/core/hgd_in_if.sv
// input item channel of the heat grid unit
`default_nettype none
interface hgd_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [hgd_pkg::KIND_W-1:0]            kind;
	logic [hgd_pkg::IDX_W-1:0]             col_index;
	logic [hgd_pkg::IDX_W-1:0]             row_index;
	logic signed [hgd_pkg::HEAT_W-1:0]     heat_value;
	logic [hgd_pkg::DIFF_W-1:0]            diffusivity_value;
	modport source (output valid, kind, col_index, row_index, heat_value, diffusivity_value,
		input ready);
	modport sink (input valid, kind, col_index, row_index, heat_value, diffusivity_value,
		output ready);
endinterface
`default_nettype wire

// File: rtl/core/hgd_out_if.sv
// result channel of the heat grid unit
`default_nettype none
interface hgd_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [hgd_pkg::HEAT_W-1:0] heat_out;
	modport source (output valid, heat_out, input ready);
	modport sink (input valid, heat_out, output ready);
endinterface
`default_nettype wire

// File: rtl/core/heat_grid_diffusion_step_unit.sv
// Heat grid diffusion step unit: double-buffered heat grid and diffusivity store in
// synchronous RAM, read-modify-write sequencer for cell access, fill and stencil step.
// After reset the unit sweeps both RAMs to zero and takes no item meanwhile. A cell write
// or an unknown kind is answered directly from idle, a read through a read state, and a
// fill writes every in-use cell in turn. A step walks the in-use grid on the single RAM
// read port: a border cell is copied to the other bank, an interior cell takes five reads,
// a shared 33x32 multiplier for the five stencil terms, then three 32x32 partial products
// for the gain scaling. Every item gives one result, held in an output register; the next
// item is taken once that result is taken.
`default_nettype none
module heat_grid_diffusion_step_unit #(
	parameter int MAX_COLS = hgd_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = hgd_pkg::MAX_ROWS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [hgd_pkg::PADDR_W-1:0]   paddr,
	input  wire [hgd_pkg::PDATA_W-1:0]   pwdata,
	output logic [hgd_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	hgd_in_if.sink                       in_ch,
	hgd_out_if.source                    out_ch
);
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CA = RW + CW;
	localparam int AW = CA + 1;
	localparam int WW = $clog2(MAX_COLS + 1);
	localparam int HW = $clog2(MAX_ROWS + 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_FILL  = 3'd3;
	localparam logic [2:0] ST_STEP  = 3'd4;

	logic [2:0] state_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] x_q;
	logic [RW-1:0] y_q;
	logic [3:0] ph_q;
	logic bank_q;
	logic rd_inside_q;
	logic signed [31:0] fill_q;

	logic [hgd_pkg::DIM_W-1:0] grid_width_q, grid_height_q;
	logic [31:0] step_gain_q, dissipation_q;
	logic signed [31:0] ambient_q;

	logic out_v_q;
	logic signed [31:0] out_heat_q;

	logic [31:0] heat_mem [2**AW];
	logic [31:0] diff_mem [2**CA];
	logic [31:0] hrd_q, drd_q;
	logic [AW-1:0] hra, hwa;
	logic [CA-1:0] dwa;
	logic hwe, dwe;
	logic [31:0] hwd, dwd;

	logic signed [31:0] h_q;
	logic signed [32:0] dh_s1;
	logic signed [32:0] co_s1;
	logic signed [65:0] prod_s2;
	logic signed [68:0] acc_q;
	logic [68:0] mag_q;
	logic neg_q;
	logic [63:0] pp_s;
	logic [100:0] sc_q;

	logic [WW-1:0] w_use;
	logic [HW-1:0] h_use;
	logic [CW-1:0] col_a;
	logic [RW-1:0] row_a;
	logic in_inside, accept, cfg_wr, last_x, last_y, border, slot_free;
	logic [44:0] q_raw;
	logic [33:0] q_sat;
	logic signed [35:0] res_w;
	logic signed [31:0] res_sat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[4:2])
			hgd_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
			hgd_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height_q);
			hgd_pkg::REG_STEP_GAIN:   prdata = step_gain_q;
			hgd_pkg::REG_AMBIENT:     prdata = ambient_q;
			hgd_pkg::REG_DISSIPATION: prdata = dissipation_q;
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= hgd_pkg::GRID_WIDTH_RST;
			grid_height_q <= hgd_pkg::GRID_HEIGHT_RST;
			step_gain_q   <= hgd_pkg::STEP_GAIN_RST;
			ambient_q     <= hgd_pkg::AMBIENT_RST;
			dissipation_q <= hgd_pkg::DISSIPATION_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				hgd_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[hgd_pkg::DIM_W-1:0];
				hgd_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[hgd_pkg::DIM_W-1:0];
				hgd_pkg::REG_STEP_GAIN:   step_gain_q   <= pwdata;
				hgd_pkg::REG_AMBIENT:     ambient_q     <= pwdata;
				hgd_pkg::REG_DISSIPATION: dissipation_q <= pwdata;
				default: ;
			endcase
		end
	end

	// in-use grid size, clamped to [3, max]
	always_comb begin
		if (grid_width_q < 7'd3) w_use = WW'(3);
		else if (32'(grid_width_q) > 32'(MAX_COLS)) w_use = WW'(MAX_COLS);
		else w_use = WW'(grid_width_q);
		if (grid_height_q < 7'd3) h_use = HW'(3);
		else if (32'(grid_height_q) > 32'(MAX_ROWS)) h_use = HW'(MAX_ROWS);
		else h_use = HW'(grid_height_q);
	end

	assign col_a = CW'(in_ch.col_index);
	assign row_a = RW'(in_ch.row_index);
	assign in_inside = (32'(in_ch.col_index) < 32'(w_use)) && (32'(in_ch.row_index) < 32'(h_use));
	assign slot_free = !out_v_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && slot_free;
	assign accept = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_v_q;
	assign out_ch.heat_out = out_heat_q;

	assign last_x = (WW'(x_q) == w_use - WW'(1));
	assign last_y = (HW'(y_q) == h_use - HW'(1));
	assign border = (x_q == '0) || (y_q == '0) || last_x || last_y;

	// final gain scaling and saturation
	assign q_raw = sc_q[100:56];
	assign q_sat = (q_raw > 45'(34'h2_0000_0000)) ? 34'h2_0000_0000 : q_raw[33:0];
	assign res_w = neg_q ? (36'(h_q) - $signed({2'b00, q_sat}))
		: (36'(h_q) + $signed({2'b00, q_sat}));
	always_comb begin
		if (res_w > 36'sh0_7FFF_FFFF) res_sat = 32'sh7FFF_FFFF;
		else if (res_w < -36'sh0_8000_0000) res_sat = 32'sh8000_0000;
		else res_sat = res_w[31:0];
	end

	// read address: neighbors follow the phase
	always_comb begin
		hra = {bank_q, row_a, col_a};
		if (state_q == ST_STEP) begin
			case (ph_q)
				4'd1:    hra = {bank_q, y_q + RW'(1), x_q};
				4'd2:    hra = {bank_q, y_q - RW'(1), x_q};
				4'd3:    hra = {bank_q, y_q, x_q + CW'(1)};
				4'd4:    hra = {bank_q, y_q, x_q - CW'(1)};
				default: hra = {bank_q, y_q, x_q};
			endcase
		end
	end

	always_comb begin
		hwe = 1'b0;
		hwa = {bank_q, y_q, x_q};
		hwd = '0;
		dwe = 1'b0;
		dwa = {row_a, col_a};
		dwd = in_ch.diffusivity_value;
		case (state_q)
			ST_CLEAR: begin
				hwe = 1'b1;
				hwa = clr_q;
				dwe = 1'b1;
				dwa = clr_q[CA-1:0];
				dwd = '0;
			end
			ST_IDLE: begin
				hwa = {bank_q, row_a, col_a};
				hwd = in_ch.heat_value;
				hwe = accept && in_inside && (in_ch.kind == hgd_pkg::KIND_WR_HEAT);
				dwe = accept && in_inside && (in_ch.kind == hgd_pkg::KIND_WR_DIFF);
			end
			ST_FILL: begin
				hwe = 1'b1;
				hwd = fill_q;
			end
			ST_STEP: begin
				hwa = {~bank_q, y_q, x_q};
				if (ph_q == 4'd1 && border) begin
					hwe = 1'b1;
					hwd = hrd_q;
				end else if (ph_q == 4'd14) begin
					hwe = 1'b1;
					hwd = res_sat;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hwe) heat_mem[hwa] <= hwd;
		hrd_q <= heat_mem[hra];
	end

	always_ff @(posedge clk) begin
		if (dwe) diff_mem[dwa] <= dwd;
		drd_q <= diff_mem[hra[CA-1:0]];
	end

	// stencil datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_STEP && ph_q == 4'd1) h_q <= hrd_q;
		if (ph_q == 4'd6) begin
			dh_s1 <= 33'(ambient_q) - 33'(h_q);
			co_s1 <= $signed({1'b0, dissipation_q});
		end else begin
			dh_s1 <= 33'($signed(hrd_q)) - 33'(h_q);
			co_s1 <= $signed({1'b0, drd_q});
		end
		prod_s2 <= 66'(dh_s1) * 66'(co_s1);
		if (ph_q == 4'd1) acc_q <= '0;
		else if (ph_q >= 4'd4 && ph_q <= 4'd8) acc_q <= acc_q + 69'(prod_s2);
		if (ph_q == 4'd9) begin
			neg_q <= acc_q[68];
			mag_q <= acc_q[68] ? 69'(-acc_q) : 69'(acc_q);
		end
		case (ph_q)
			4'd10:   pp_s <= 64'(mag_q[31:0]) * 64'(step_gain_q);
			4'd11:   pp_s <= 64'(mag_q[63:32]) * 64'(step_gain_q);
			4'd12:   pp_s <= 64'({27'd0, mag_q[68:64]}) * 64'(step_gain_q);
			default: pp_s <= pp_s;
		endcase
		case (ph_q)
			4'd11:   sc_q <= 101'(pp_s);
			4'd12:   sc_q <= sc_q + {5'd0, pp_s, 32'd0};
			4'd13:   sc_q <= sc_q + {pp_s[36:0], 64'd0};
			default: sc_q <= sc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fill_q <= in_ch.heat_value;
			rd_inside_q <= in_inside;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			x_q <= '0;
			y_q <= '0;
			ph_q <= '0;
			bank_q <= 1'b0;
			out_v_q <= 1'b0;
			out_heat_q <= '0;
		end else begin
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						x_q <= '0;
						y_q <= '0;
						ph_q <= '0;
						case (in_ch.kind)
							hgd_pkg::KIND_RD_HEAT: state_q <= ST_READ;
							hgd_pkg::KIND_STEP:    state_q <= ST_STEP;
							hgd_pkg::KIND_FILL:    state_q <= ST_FILL;
							default: begin
								out_v_q <= 1'b1;
								out_heat_q <= '0;
							end
						endcase
					end
				end
				ST_READ: begin
					out_v_q <= 1'b1;
					out_heat_q <= rd_inside_q ? hrd_q : '0;
					state_q <= ST_IDLE;
				end
				ST_FILL: begin
					x_q <= last_x ? '0 : x_q + CW'(1);
					if (last_x) y_q <= y_q + RW'(1);
					if (last_x && last_y) begin
						out_v_q <= 1'b1;
						out_heat_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_STEP: begin
					ph_q <= ph_q + 4'd1;
					// a border cell finishes after the copy, an interior one after the update
					if ((ph_q == 4'd1 && border) || ph_q == 4'd14) begin
						ph_q <= '0;
						x_q <= last_x ? '0 : x_q + CW'(1);
						if (last_x) y_q <= y_q + RW'(1);
						if (last_x && last_y) begin
							bank_q <= ~bank_q;
							out_v_q <= 1'b1;
							out_heat_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (state_q == ST_IDLE && !(out_v_q && !out_ch.ready)))
		else $error("input ready outside idle");
	a_step_writes_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && hwe) |-> (hwa[AW-1] != bank_q))
		else $error("step wrote the active bank");
	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_q != $past(bank_q)) |-> ($past(state_q) == ST_STEP && out_v_q))
		else $error("bank flipped outside a step end");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ch.ready)
		else $error("item taken during clearing");
endmodule
`default_nettype wire

// File: dv/heat_grid_diffusion_step_unit_tb.sv
// testbench for the heat grid diffusion step unit: directed and random cell traffic and steps, checked
`timescale 1ns / 1ps
module heat_grid_diffusion_step_unit_tb;
	localparam int GRID_CELLS = hgd_pkg::MAX_COLS_DEF * hgd_pkg::MAX_ROWS_DEF;
	localparam int STALL_LIMIT = 300000;
	localparam int HOLD_CYCLES = 60;

	// grid model plus store of expected heat_out values
	class heat_scoreboard;
		logic [31:0] heat_bank[2][GRID_CELLS];
		logic [31:0] diff_cell[GRID_CELLS];
		bit active;
		logic [6:0] width_reg, height_reg;
		logic [31:0] gain, ambient, dissip;
		logic [31:0] pending_heat[$];
		int mismatches, checked;

		function void clear();
			foreach (diff_cell[i]) begin
				heat_bank[0][i] = '0;
				heat_bank[1][i] = '0;
				diff_cell[i] = '0;
			end
			active = 0;
			width_reg = hgd_pkg::GRID_WIDTH_RST;
			height_reg = hgd_pkg::GRID_HEIGHT_RST;
			gain = hgd_pkg::STEP_GAIN_RST;
			ambient = hgd_pkg::AMBIENT_RST;
			dissip = hgd_pkg::DISSIPATION_RST;
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] val);
			case (idx)
				hgd_pkg::REG_GRID_WIDTH: width_reg = val[6:0];
				hgd_pkg::REG_GRID_HEIGHT: height_reg = val[6:0];
				hgd_pkg::REG_STEP_GAIN: gain = val;
				hgd_pkg::REG_AMBIENT: ambient = val;
				hgd_pkg::REG_DISSIPATION: dissip = val;
				default: ;
			endcase
		endfunction

		function int used_dim(logic [6:0] v, int maxv);
			if (v < 3) return 3;
			if (v > maxv) return maxv;
			return v;
		endfunction

		function logic [31:0] stencil_heat(bit b, int x, int y);
			int c, n;
			int nbr[5];
			logic signed [79:0] acc;
			logic signed [33:0] d;
			logic signed [33:0] hs;
			logic [79:0] mag;
			logic [111:0] prod;
			logic [63:0] q;
			logic signed [63:0] r;
			logic [31:0] coef;
			c = y * hgd_pkg::MAX_COLS_DEF + x;
			nbr[0] = c + hgd_pkg::MAX_COLS_DEF;
			nbr[1] = c - hgd_pkg::MAX_COLS_DEF;
			nbr[2] = c + 1;
			nbr[3] = c - 1;
			hs = $signed({{2{heat_bank[b][c][31]}}, heat_bank[b][c]});
			acc = '0;
			for (n = 0; n < 5; n++) begin
				if (n < 4) begin
					d = $signed({{2{heat_bank[b][nbr[n]][31]}}, heat_bank[b][nbr[n]]}) - hs;
					coef = diff_cell[nbr[n]];
				end else begin
					d = $signed({{2{ambient[31]}}, ambient}) - hs;
					coef = dissip;
				end
				acc = acc + d * $signed({1'b0, coef});
			end
			mag = acc[79] ? -acc : acc;
			prod = mag * gain;
			q = prod[111:56];
			if (q > (64'd1 << 33)) q = 64'd1 << 33;
			r = acc[79] ? hs - $signed(q) : hs + $signed(q);
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			return r[31:0];
		endfunction

		function void note_input(logic [2:0] kind, logic [5:0] col, logic [5:0] row,
				logic [31:0] heat, logic [31:0] diffv);
			int w, h, c, x, y;
			bit on_grid;
			logic [31:0] result;
			w = used_dim(width_reg, hgd_pkg::MAX_COLS_DEF);
			h = used_dim(height_reg, hgd_pkg::MAX_ROWS_DEF);
			on_grid = col < w && row < h;
			c = row * hgd_pkg::MAX_COLS_DEF + col;
			result = '0;
			case (kind)
				hgd_pkg::KIND_WR_HEAT: if (on_grid) heat_bank[active][c] = heat;
				hgd_pkg::KIND_WR_DIFF: if (on_grid) diff_cell[c] = diffv;
				hgd_pkg::KIND_RD_HEAT: if (on_grid) result = heat_bank[active][c];
				hgd_pkg::KIND_STEP: begin
					for (y = 0; y < h; y++)
						for (x = 0; x < w; x++)
							if (x == 0 || y == 0 || x == w - 1 || y == h - 1)
								heat_bank[!active][y * hgd_pkg::MAX_COLS_DEF + x] =
									heat_bank[active][y * hgd_pkg::MAX_COLS_DEF + x];
							else
								heat_bank[!active][y * hgd_pkg::MAX_COLS_DEF + x] =
									stencil_heat(active, x, y);
					active = !active;
				end
				hgd_pkg::KIND_FILL: begin
					for (y = 0; y < h; y++)
						for (x = 0; x < w; x++)
							heat_bank[active][y * hgd_pkg::MAX_COLS_DEF + x] = heat;
				end
				default: ;
			endcase
			pending_heat.push_back(result);
		endfunction

		function void check_result(logic [31:0] got);
			logic [31:0] want;
			checked++;
			if (pending_heat.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result heat_out=%h", $realtime, got);
				return;
			end
			want = pending_heat.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: heat_out mismatch expected %h actual %h",
						$realtime, want, got);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [hgd_pkg::PADDR_W-1:0] paddr;
	logic [hgd_pkg::PDATA_W-1:0] pwdata;
	logic [hgd_pkg::PDATA_W-1:0] prdata;
	logic pready;

	hgd_in_if in_ch();
	hgd_out_if out_ch();

	heat_grid_diffusion_step_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	heat_scoreboard grid_sb;
	bit no_gaps;
	int hold_asks, hold_taken, hold_left;
	int idle_count;
	int n_items, n_steps, n_reads;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		grid_sb = new();
		grid_sb.clear();
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_ch.valid = 0; in_ch.kind = '0; in_ch.col_index = '0; in_ch.row_index = '0;
		in_ch.heat_value = '0; in_ch.diffusivity_value = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
	end

	// result side: random stalls, and a long hold-off counted here on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ch.ready <= 0;
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_asks) begin
			out_ch.ready <= 0;
			hold_taken <= hold_asks;
			hold_left <= HOLD_CYCLES - 1;
		end else begin
			out_ch.ready <= no_gaps || ($urandom_range(99) >= 16);
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			grid_sb.note_input(in_ch.kind, in_ch.col_index, in_ch.row_index,
				in_ch.heat_value, in_ch.diffusivity_value);
			n_items++;
			if (in_ch.kind == hgd_pkg::KIND_STEP) n_steps++;
			if (in_ch.kind == hgd_pkg::KIND_RD_HEAT) n_reads++;
		end
		if (arst_n && out_ch.valid && out_ch.ready)
			grid_sb.check_result(out_ch.heat_out);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("%0t: watchdog expired", $realtime);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= hgd_pkg::PADDR_W'({idx, 2'b00}); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		grid_sb.set_register(idx, val);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_item(logic [2:0] kind, logic [5:0] col, logic [5:0] row,
			logic [31:0] heat, logic [31:0] diffv);
		if (!no_gaps && $urandom_range(99) < 16) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.kind <= kind;
		in_ch.col_index <= col;
		in_ch.row_index <= row;
		in_ch.heat_value <= heat;
		in_ch.diffusivity_value <= diffv;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		// let the last transfer reach the scoreboard first
		@(posedge clk);
		while (grid_sb.pending_heat.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_heat();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(32'h3ffff) - 32'h1ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_diff();
		case ($urandom_range(4))
			0: return 32'hffffffff;
			1: return '0;
			2: return $urandom_range(32'h3fffff);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_burst(int count, int big_steps);
		int w, h, r;
		logic [2:0] kind;
		logic [5:0] col, row;
		w = grid_sb.used_dim(grid_sb.width_reg, hgd_pkg::MAX_COLS_DEF);
		h = grid_sb.used_dim(grid_sb.height_reg, hgd_pkg::MAX_ROWS_DEF);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 30) kind = hgd_pkg::KIND_WR_HEAT;
			else if (r < 50) kind = hgd_pkg::KIND_WR_DIFF;
			else if (r < 80) kind = hgd_pkg::KIND_RD_HEAT;
			else if (r < 91) kind = hgd_pkg::KIND_STEP;
			else if (r < 95) kind = hgd_pkg::KIND_FILL;
			else kind = 3'($urandom_range(5, 7));
			// large grids are slow to step: at most big_steps steps there
			if (kind == hgd_pkg::KIND_STEP && w * h > 160) begin
				if (big_steps > 0) big_steps--;
				else kind = hgd_pkg::KIND_RD_HEAT;
			end
			if ($urandom_range(9) == 0) begin
				col = 6'($urandom); row = 6'($urandom);
			end else begin
				col = 6'($urandom_range(w - 1)); row = 6'($urandom_range(h - 1));
			end
			if (i == count / 2) hold_asks++;
			if (i == count / 3) no_gaps = 1;
			if (i == 2 * count / 3) no_gaps = 0;
			send_item(kind, col, row, pick_heat(), pick_diff());
		end
		drain();
	endtask

	initial begin
		logic [31:0] phase_cfg[8][5];
		phase_cfg = '{
			'{32'd5, 32'd5, 32'h00010000, 32'h00000000, 32'd1099512},
			'{32'd0, 32'd1, 32'hffffffff, 32'h7fffffff, 32'hffffffff},
			'{32'd8, 32'd6, 32'h00000000, 32'h80000000, 32'd0},
			'{32'd12, 32'd3, 32'h00400000, 32'h00050000, 32'h00100000},
			'{32'd127, 32'd2, 32'h00008000, 32'hfffb0000, 32'd1099512},
			'{32'd3, 32'd127, 32'hffffffff, 32'h80000000, 32'hffffffff},
			'{32'd64, 32'd64, 32'h00010000, 32'h00000000, 32'd1099512},
			'{32'd10, 32'd9, 32'h12345678, 32'h00800000, 32'h00a00000}
		};
		no_gaps = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// directed: corner cells, extremes, unknown kinds, one full-size step
		send_item(hgd_pkg::KIND_WR_HEAT, 6'd0, 6'd0, 32'h7fffffff, '0);
		send_item(hgd_pkg::KIND_WR_HEAT, 6'd63, 6'd63, 32'h80000000, '0);
		send_item(hgd_pkg::KIND_WR_HEAT, 6'd1, 6'd2, 32'h80000000, '0);
		send_item(hgd_pkg::KIND_WR_HEAT, 6'd1, 6'd1, 32'h7fffffff, '0);
		send_item(hgd_pkg::KIND_WR_DIFF, 6'd1, 6'd2, '0, 32'hffffffff);
		send_item(hgd_pkg::KIND_WR_DIFF, 6'd2, 6'd1, '0, 32'hffffffff);
		send_item(hgd_pkg::KIND_WR_DIFF, 6'd62, 6'd62, '0, 32'h00010000);
		send_item(hgd_pkg::KIND_RD_HEAT, 6'd0, 6'd0, '0, '0);
		send_item(hgd_pkg::KIND_RD_HEAT, 6'd63, 6'd63, '0, '0);
		send_item(3'd5, 6'd1, 6'd1, 32'h12345678, 32'hffffffff);
		send_item(3'd6, 6'd1, 6'd1, 32'h12345678, 32'hffffffff);
		send_item(3'd7, 6'd63, 6'd0, 32'hffffffff, 32'hffffffff);
		send_item(hgd_pkg::KIND_RD_HEAT, 6'd1, 6'd1, '0, '0);
		send_item(hgd_pkg::KIND_STEP, 6'd0, 6'd0, '0, '0);
		send_item(hgd_pkg::KIND_RD_HEAT, 6'd1, 6'd1, '0, '0);
		send_item(hgd_pkg::KIND_RD_HEAT, 6'd1, 6'd2, '0, '0);
		send_item(hgd_pkg::KIND_RD_HEAT, 6'd0, 6'd0, '0, '0);
		send_item(hgd_pkg::KIND_FILL, 6'd0, 6'd0, 32'hfffe0000, '0);
		send_item(hgd_pkg::KIND_RD_HEAT, 6'd63, 6'd0, '0, '0);
		send_item(hgd_pkg::KIND_RD_HEAT, 6'd63, 6'd63, '0, '0);
		drain();

		foreach (phase_cfg[p]) begin
			reg_write(hgd_pkg::REG_GRID_WIDTH, phase_cfg[p][0]);
			reg_write(hgd_pkg::REG_GRID_HEIGHT, phase_cfg[p][1]);
			reg_write(hgd_pkg::REG_STEP_GAIN, phase_cfg[p][2]);
			reg_write(hgd_pkg::REG_AMBIENT, phase_cfg[p][3]);
			reg_write(hgd_pkg::REG_DISSIPATION, phase_cfg[p][4]);
			random_burst(235, 1);
		end

		$display("covered %0d items over %0d settings: %0d steps, %0d reads",
			n_items, 9, n_steps, n_reads);
		$display("results checked %0d, mismatches %0d", grid_sb.checked, grid_sb.mismatches);
		if (grid_sb.mismatches == 0 && grid_sb.pending_heat.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// File: heat_grid_diffusion_step_unit.f
rtl/core/hgd_pkg.sv
rtl/core/hgd_in_if.sv
rtl/core/hgd_out_if.sv
rtl/core/heat_grid_diffusion_step_unit.sv
dv/heat_grid_diffusion_step_unit_tb.sv
